// File: design/indexed_list_engine_defines.svh
// Assertion macros used by the indexed list engine port-level checker.
`ifndef INDEXED_LIST_ENGINE_DEFINES_SVH
`define INDEXED_LIST_ENGINE_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ILE_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ILE_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ile_pkg.sv
// Shared types and constants of the indexed list engine.
package ile_pkg;

  localparam int DEPTH_DEF   = 16;
  localparam int POS_W       = 8;
  localparam int WORD_W      = 32;
  localparam int LEN_W       = 5;
  localparam int CMD_W       = 2;
  localparam int ST_W        = 2;
  localparam int IN_TDATA_W  = 40;  // position + value
  localparam int OUT_TDATA_W = 40;  // entry + length, padded to bytes

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_READ   = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;  // capture the incoming item
    logic exec;  // run the captured item and load the result register
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register empty or being drained this cycle
  } dp_stat_t;

endpackage

// File: design/ile_ctrl.sv
// Controller state machine of the indexed list engine.
module ile_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  ile_pkg::dp_stat_t stat,
  output ile_pkg::ctrl_cmd_t cmd
);
  import ile_pkg::*;

  state_e state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        // wait for room in the result register
        if (stat.out_free) begin
          cmd.exec   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: design/ile_dp.sv
// Datapath of the indexed list engine: entry registers, count and result register.
module ile_dp #(
  parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  ile_pkg::ctrl_cmd_t              cmd,
  output ile_pkg::dp_stat_t               stat,
  input  logic [ile_pkg::CMD_W-1:0]       in_cmd,
  input  logic [ile_pkg::POS_W-1:0]       in_pos,
  input  logic [ile_pkg::WORD_W-1:0]      in_val,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ile_pkg::OUT_TDATA_W-1:0] m_tdata,
  output logic [ile_pkg::ST_W-1:0]        m_tuser
);
  import ile_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = POS_W + 1;
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam int PAD_W = OUT_TDATA_W - WORD_W - LEN_W;

  logic [WORD_W-1:0] entries [DEPTH];
  logic [CNT_W-1:0]  count, count_next;

  logic [CMD_W-1:0]  cmd_q;
  logic [POS_W-1:0]  pos_q;
  logic [WORD_W-1:0] val_q;

  logic              in_range;
  logic              do_append;
  logic              do_remove;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] res_entry;
  status_e           res_status;

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= in_cmd;
      pos_q <= in_pos;
      val_q <= in_val;
    end
  end

  assign in_range = CMP_W'(pos_q) < CMP_W'(count);
  assign rd_word  = entries[pos_q[IDX_W-1:0]];

  always_comb begin
    res_entry  = '0;
    res_status = ST_OK;
    do_append  = 1'b0;
    do_remove  = 1'b0;
    count_next = count;
    case (cmd_q)
      CMD_APPEND: begin
        if (count != DEPTH_C) begin
          do_append  = 1'b1;
          count_next = count + CNT_W'(1);
        end else begin
          res_status = ST_FULL;
        end
      end
      CMD_READ, CMD_REMOVE: begin
        if (in_range) begin
          res_entry = rd_word;
          if (cmd_q == CMD_REMOVE) begin
            do_remove  = 1'b1;
            count_next = count - CNT_W'(1);
          end
        end else begin
          res_entry  = '1;
          res_status = ST_OOB;
        end
      end
      default: begin
        // unused command: no change
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // entry registers: append writes at the tail, remove moves later entries down
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    if (i < DEPTH - 1) begin : g_shift
      always_ff @(posedge clk) begin
        if (cmd.exec && do_remove && CMP_W'(i) >= CMP_W'(pos_q)
            && CMP_W'(i + 1) < CMP_W'(count)) begin
          entries[i] <= entries[i + 1];
        end else if (cmd.exec && do_append && count[IDX_W-1:0] == IDX_W'(i)) begin
          entries[i] <= val_q;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk) begin
        if (cmd.exec && do_append && count[IDX_W-1:0] == IDX_W'(i)) begin
          entries[i] <= val_q;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      m_tdata <= {PAD_W'(0), LEN_W'(count_next), res_entry};
      m_tuser <= res_status;
    end
  end

  assign stat.out_free = !m_tvalid || m_tready;

endmodule

// File: design/indexed_list_engine.sv
// An accepted item is captured, then executed into the result register once that
// register is free, which raises m_tvalid. The capture/execute controller takes
// one item at a time, and execution waits only for the result register.
// A remove shifts all later entries down in the execute cycle.
// Reset (rst, synchronous, active high) empties the list and the result
// register; entry contents are not cleared and are only read once written.
module indexed_list_engine #(
  parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // input items
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [ile_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] position, [39:8] value
  input  logic [ile_pkg::CMD_W-1:0]       s_tuser,   // [1:0] cmd
  // result items
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [ile_pkg::OUT_TDATA_W-1:0] m_tdata,   // [31:0] entry, [36:32] length, zero pad
  output logic [ile_pkg::ST_W-1:0]        m_tuser    // [1:0] status
);
  import ile_pkg::*;

  ctrl_cmd_t ctrl;
  dp_stat_t  stat;

  // Controller: idle takes an item, execute retires it into the result
  // register as soon as that register is free.
  ile_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (ctrl)
  );

  // Datapath: list registers, count, and the output register that lets the
  // next item in while a result is still waiting downstream.
  ile_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (ctrl),
    .stat     (stat),
    .in_cmd   (s_tuser),
    .in_pos   (s_tdata[POS_W-1:0]),
    .in_val   (s_tdata[POS_W +: WORD_W]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// File: design/ile_checker.sv
// Port-level checker of the indexed list engine and its bind.
`include "indexed_list_engine_defines.svh"

module ile_checker #(
  parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
  input logic                            clk,
  input logic                            rst,
  input logic                            s_tvalid,
  input logic                            s_tready,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ile_pkg::OUT_TDATA_W-1:0] m_tdata,
  input logic [ile_pkg::ST_W-1:0]        m_tuser
);
  import ile_pkg::*;

  logic                          in_acc;
  logic                          out_stall;
  logic                          oob_res;
  logic                          full_res;
  logic [ST_W+OUT_TDATA_W:0]     out_word;
  logic [LEN_W-1:0]              out_len;

  assign in_acc    = s_tvalid && s_tready;
  assign out_stall = m_tvalid && !m_tready;
  assign oob_res   = m_tvalid && m_tuser == ST_OOB;
  assign full_res  = m_tvalid && m_tuser == ST_FULL;
  assign out_word  = {m_tvalid, m_tuser, m_tdata};
  assign out_len   = m_tdata[WORD_W +: LEN_W];

  // result held while stalled
  `ILE_ASSERT_NXT(a_hold, clk, rst, out_stall, $stable(out_word), "stalled result changed")

  // one item in flight: no accept right after an accept
  `ILE_ASSERT_NXT(a_one_item, clk, rst, in_acc, !s_tready, "accept while busy")

  // out-of-bound results carry -1
  `ILE_ASSERT_NOW(a_oob_entry, clk, rst, oob_res, m_tdata[WORD_W-1:0] == '1, "oob entry not -1")

  // a dropped append reports a full list
  `ILE_ASSERT_NOW(a_full_len, clk, rst, full_res, out_len == LEN_W'(DEPTH), "full, length short")

endmodule

bind indexed_list_engine ile_checker #(.DEPTH(DEPTH)) u_ile_checker (.*);

// File: dv/indexed_list_checker.sv
// Result predictor and scoreboard for the indexed list engine item channels.
module indexed_list_checker #(
  parameter int DEPTH = ile_pkg::DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [ile_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] position, [39:8] value
  input  logic [ile_pkg::CMD_W-1:0]       s_tuser,   // [1:0] cmd
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [ile_pkg::OUT_TDATA_W-1:0] m_tdata,   // [31:0] entry, [36:32] length, zero pad
  input  logic [ile_pkg::ST_W-1:0]        m_tuser,   // [1:0] status
  output int                              fail_count,
  output int                              pending
);
  import ile_pkg::*;

  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [WORD_W-1:0] entry;
    logic [ST_W-1:0]   status;
    logic [LEN_W-1:0]  length;
  } list_result_t;

  logic [WORD_W-1:0] shadow_entries [DEPTH];
  int unsigned       shadow_len;
  list_result_t      expected_results [$];
  int                fails;

  // Applies one command to the shadow list and returns the result it gives.
  function automatic list_result_t predict_list_op(input logic [CMD_W-1:0] op,
                                                   input logic [POS_W-1:0] pos,
                                                   input logic [WORD_W-1:0] val);
    list_result_t r;
    r.entry  = '0;
    r.status = ST_OK;
    case (op)
      CMD_APPEND: begin
        if (shadow_len < DEPTH) begin
          shadow_entries[shadow_len] = val;
          shadow_len++;
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_READ, CMD_REMOVE: begin
        if (pos < shadow_len) begin
          r.entry = shadow_entries[pos];
          if (op == CMD_REMOVE) begin
            for (int unsigned i = pos; i + 1 < shadow_len; i++)
              shadow_entries[i] = shadow_entries[i + 1];
            shadow_len--;
          end
        end else begin
          r.entry  = '1;
          r.status = ST_OOB;
        end
      end
      default: ;  // unused code: no change
    endcase
    r.length = shadow_len[LEN_W-1:0];
    return r;
  endfunction

  function automatic void note_failure(input string msg);
    fails++;
    if (fails <= REPORT_MAX)
      $display("%0t list checker: %s", $realtime, msg);
  endfunction

  always @(posedge clk) begin
    list_result_t got;
    list_result_t want;
    if (rst) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      if (s_tvalid && s_tready)
        expected_results.push_back(predict_list_op(s_tuser, s_tdata[POS_W-1:0],
                                                   s_tdata[POS_W +: WORD_W]));
      if (m_tvalid && m_tready) begin
        got.entry  = m_tdata[WORD_W-1:0];
        got.length = m_tdata[WORD_W +: LEN_W];
        got.status = m_tuser;
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result entry=%0d status=%0d length=%0d",
                                 $signed(got.entry), got.status, got.length));
        end else begin
          want = expected_results.pop_front();
          if (got.entry !== want.entry)
            note_failure($sformatf("entry: expected %0d, got %0d",
                                   $signed(want.entry), $signed(got.entry)));
          if (got.status !== want.status)
            note_failure($sformatf("status: expected %0d, got %0d",
                                   want.status, got.status));
          if (got.length !== want.length)
            note_failure($sformatf("length: expected %0d, got %0d",
                                   want.length, got.length));
          if (m_tdata[OUT_TDATA_W-1:WORD_W+LEN_W] !== '0)
            note_failure($sformatf("pad bits: expected 0, got %0h",
                                   m_tdata[OUT_TDATA_W-1:WORD_W+LEN_W]));
        end
      end
    end
    fail_count <= fails;
    pending    <= expected_results.size();
  end

endmodule

// File: dv/testbench.sv
// Top of the indexed list engine testbench: clock, reset, item stimulus and verdict.
module testbench;
  import ile_pkg::*;

  localparam int               LIST_DEPTH      = DEPTH_DEF;
  localparam logic [CMD_W-1:0] CMD_UNUSED      = 2'd3;   // code that leaves the list unchanged
  localparam int               RANDOM_ITEMS    = 1150;
  localparam int               HOLD_OFF_CYCLES = 300;    // long receiver stall
  localparam int               DRAIN_CYCLES    = 8;      // extra wait after the last result
  localparam int unsigned      CYCLE_LIMIT     = 200000;
  localparam int               RESET_CYCLES    = 12;

  logic                   clk      = 1'b0;
  logic                   rst      = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata  = '0;   // [7:0] position, [39:8] value
  logic [CMD_W-1:0]       s_tuser  = '0;   // [1:0] cmd
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;         // [31:0] entry, [36:32] length, zero pad
  logic [ST_W-1:0]        m_tuser;         // [1:0] status

  // Idle odds in percent per cycle for each side, and the pending receiver stall.
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_left     = 0;
  int unsigned cycle_count   = 0;
  int          fail_count;
  int          pending;

  indexed_list_engine #(.DEPTH(LIST_DEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  indexed_list_checker #(.DEPTH(LIST_DEPTH)) list_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure, or a solid stall while hold_left runs down.
  initial begin
    forever begin
      @(negedge clk);
      if (hold_left != 0) begin
        m_tready <= 1'b0;
        hold_left--;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Offers one item from a falling edge and returns on the falling edge after
  // it is taken, so tvalid stays high across back-to-back items.
  task automatic send_item(input logic [CMD_W-1:0] op, input logic [POS_W-1:0] pos,
                           input logic [WORD_W-1:0] val);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {val, pos};
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  // Empty list, fill with edge values, overflow, reads and removes at the ends and in the middle, an unused command.
  task automatic run_directed();
    logic [WORD_W-1:0] v;
    send_item(CMD_READ, 8'd0, '0);             // read from an empty list
    for (int i = 0; i < LIST_DEPTH; i++) begin
      case (i)
        0:       v = 32'h8000_0000;
        1:       v = 32'h7FFF_FFFF;
        2:       v = '1;
        3:       v = '0;
        4:       v = 32'hAAAA_AAAA;
        5:       v = 32'h5555_5555;
        default: v = $urandom();
      endcase
      send_item(CMD_APPEND, POS_W'(i), v);
    end
    send_item(CMD_APPEND, 8'hFF, 32'h1234_5678);          // full: dropped
    send_item(CMD_READ, POS_W'(LIST_DEPTH - 1), '0);      // last entry
    send_item(CMD_READ, POS_W'(LIST_DEPTH), '1);          // just past the end
    send_item(CMD_REMOVE, 8'hFF, '0);                     // far past the end
    send_item(CMD_REMOVE, POS_W'(LIST_DEPTH - 1), '0);    // remove tail
    send_item(CMD_REMOVE, 8'd0, '0);                      // remove head, all shift
    send_item(CMD_REMOVE, 8'd7, '0);                      // remove from the middle
    send_item(CMD_UNUSED, 8'd3, '1);
  endtask

  // Random commands; the mix swings between growing and shrinking the list
  // every 48 items so both full and near-empty states come up.
  task automatic send_random(input int unsigned n);
    logic [CMD_W-1:0]  op;
    logic [POS_W-1:0]  pos;
    logic [WORD_W-1:0] val;
    int unsigned       roll;
    int unsigned       grow_w;
    int unsigned       shrink_w;
    for (int unsigned k = 0; k < n; k++) begin
      if ((k / 48) % 2 == 0) begin
        grow_w   = 60;
        shrink_w = 22;
      end else begin
        grow_w   = 22;
        shrink_w = 46;
      end
      roll = $urandom_range(99);
      if (roll < 2)
        op = CMD_UNUSED;
      else if (roll < 2 + grow_w)
        op = CMD_APPEND;
      else if (roll < 2 + grow_w + shrink_w)
        op = CMD_REMOVE;
      else
        op = CMD_READ;
      // mostly near the live range, sometimes anywhere in the field
      if ($urandom_range(7) == 0)
        pos = POS_W'($urandom_range(255));
      else
        pos = POS_W'($urandom_range(LIST_DEPTH + 1));
      case ($urandom_range(9))
        0:       val = 32'h8000_0000;
        1:       val = 32'h7FFF_FFFF;
        2:       val = '1;
        default: val = $urandom();
      endcase
      send_item(op, pos, val);
    end
  endtask

  initial begin
    send_idle_pct = 29;
    recv_idle_pct = 71;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    run_directed();
    send_random(RANDOM_ITEMS / 3);

    send_idle_pct = 71;
    recv_idle_pct = 29;
    send_random(RANDOM_ITEMS / 3);

    // no idling; start with a long receiver stall so the block backs up
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = HOLD_OFF_CYCLES;
    send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
